>>> hw/rtl/hermitian3x3_inverse_adjugate_core_assert.svh
// Assertion macros for the checker file of the Hermitian 3x3 inverse core.
`ifndef HERMITIAN3X3_INVERSE_ADJUGATE_CORE_ASSERT_SVH
`define HERMITIAN3X3_INVERSE_ADJUGATE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define H3INV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define H3INV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/h3inv_pkg.sv
// Shared constants, tables and types of the Hermitian 3x3 inverse core.
`default_nettype none
package h3inv_pkg;

    localparam int FIELD_W           = 32;
    localparam int NUM_IN            = 9;
    localparam int NUM_COF           = 9;
    localparam int NUM_PROD          = 27;
    localparam int NUM_DET_TERMS     = 5;
    localparam int S_TDATA_W         = NUM_IN * FIELD_W;
    localparam int DET_W             = 64;
    localparam int INV_BITS          = NUM_COF * FIELD_W;
    localparam int M_TDATA_W         = INV_BITS + DET_W;
    localparam int M_TUSER_W         = 2;
    localparam int TUSER_SINGULAR    = 0;
    localparam int TUSER_SATURATED   = 1;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam logic REG_DET_ONLY    = 1'b0;

    // Input order: d00 d11 d22 a_re a_im b_re b_im c_re c_im (a=01, b=02, c=12).
    // Three products per cofactor; cofactor k = p0 +/- p1 - p2.
    localparam int PROD_A [NUM_PROD] = '{1, 7, 8,  0, 5, 6,  0, 3, 4,
                                         5, 6, 3,  6, 5, 4,  3, 4, 5,
                                         3, 4, 6,  5, 6, 0,  6, 5, 0};
    localparam int PROD_B [NUM_PROD] = '{2, 7, 8,  2, 5, 6,  1, 3, 4,
                                         7, 8, 2,  7, 8, 2,  7, 8, 1,
                                         8, 7, 1,  3, 4, 7,  3, 4, 8};
    // Bit k set: middle product is added for cofactor k.
    localparam logic [NUM_COF-1:0] COF_ADD = 9'b011001000;

    // Determinant along the first row: input times cofactor.
    localparam int DET_IN  [NUM_DET_TERMS] = '{0, 3, 4, 5, 6};
    localparam int DET_COF [NUM_DET_TERMS] = '{0, 3, 4, 5, 6};

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/hermitian3x3_inverse_adjugate_core.sv
// Top level of the streaming Hermitian 3x3 inverse core (adjugate method).
`default_nettype none
// Inverts one 3x3 Hermitian matrix per item and also reports its determinant.
// Takes one item every clock unless the queue is full, and gives one result per
// clock while m_tready is high. The input register loads at the accepting edge,
// then come 5 front stages (27 products, cofactors, split determinant multiplies,
// product merge, determinant sum), the queue, and W+3 back stages (abs/rounding,
// range check, W restoring-division stages that make one quotient bit each for all
// nine entries, output register), W = min(DATA_WIDTH, 32).
// The division pipeline sets the latency; throughput is one item per clock.
// A 4-entry queue decouples the parts: the back stalls on m_tready alone, and
// s_tready only drops when the queue is full. Inverse entries round half away
// from zero and saturate to W bits; the determinant rounds half up and saturates
// to 64 bits. A zero determinant sets singular and zeroes the inverse.
// Register 0 (byte 0), bit 0: determinant only; write it only while idle.
module hermitian3x3_inverse_adjugate_core #(
    parameter int DATA_WIDTH    = h3inv_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = h3inv_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = h3inv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [h3inv_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [h3inv_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [h3inv_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // diag_00, diag_11, diag_22, off_01_re, off_01_im, off_02_re, off_02_im,
    // off_12_re, off_12_im; 32 bits each from bit 0 up
    input  wire logic [h3inv_pkg::S_TDATA_W-1:0]     s_tdata,
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // inv_00, inv_11, inv_22, inv_01_re, inv_01_im, inv_02_re, inv_02_im,
    // inv_12_re, inv_12_im (32 bits each), det_value (64 bits); from bit 0 up
    output logic [h3inv_pkg::M_TDATA_W-1:0]          m_tdata,
    // singular (bit 0), saturated (bit 1)
    output logic [h3inv_pkg::M_TUSER_W-1:0]          m_tuser
);
    localparam int W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int QW  = h3inv_pkg::NUM_COF * (2*W + 2) + 3*W + 5;

    // Configuration register
    logic det_only_reg;
    logic cfg_wr;
    logic cfg_sel;

    assign cfg_sel = (paddr[h3inv_pkg::CFG_ADDR_W-1:2] == h3inv_pkg::REG_DET_ONLY);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? h3inv_pkg::CFG_DATA_W'(det_only_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_only_reg <= 1'b0;
        end else if (cfg_wr) begin
            det_only_reg <= pwdata[0];
        end
    end

    // Front -> queue -> back
    logic                  push, pop;
    logic [QW-1:0]         push_data, pop_data;
    h3inv_pkg::q_status_t  q_stat;

    h3inv_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_full    (q_stat.full),
        .push      (push),
        .push_data (push_data)
    );

    h3inv_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    h3inv_back #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (!q_stat.empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .det_only  (det_only_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire

>>> hw/rtl/h3inv_front.sv
// Front part: input register, cofactors and exact determinant, pipelined.
`default_nettype none
module h3inv_front #(
    parameter int DATA_WIDTH = h3inv_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [h3inv_pkg::S_TDATA_W-1:0]     in_data,
    input  wire logic                                q_full,
    output logic                                     push,
    output logic [h3inv_pkg::NUM_COF*(2*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)+2)
                  + 3*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)+5-1:0] push_data
);
    localparam int W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int CW  = 2*W + 2;
    localparam int DTW = 3*W + 5;
    localparam int LOW = W;
    localparam int HIW = CW - LOW;
    localparam int NC  = h3inv_pkg::NUM_COF;
    localparam int NP  = h3inv_pkg::NUM_PROD;
    localparam int ND  = h3inv_pkg::NUM_DET_TERMS;

    logic en;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [W-1:0]       x_reg   [h3inv_pkg::NUM_IN];
    logic signed [2*W-1:0]     p_reg   [NP];
    logic signed [W-1:0]       xs1_reg [ND];
    logic signed [W-1:0]       xs2_reg [ND];
    logic signed [CW-1:0]      cof_c   [NC];
    logic signed [CW-1:0]      cof2_reg[NC];
    logic signed [CW-1:0]      cof3_reg[NC];
    logic signed [CW-1:0]      cof4_reg[NC];
    logic signed [CW-1:0]      cof5_reg[NC];
    logic signed [W+LOW:0]     plo_reg [ND];
    logic signed [W+HIW-1:0]   phi_reg [ND];
    logic signed [DTW-1:0]     dp_reg  [ND];
    logic signed [DTW-1:0]     det_reg;

    // Whole front holds only when its last item cannot enter the queue.
    assign en       = !(v5_reg && q_full);
    assign in_ready = en;
    assign push     = v5_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < h3inv_pkg::NUM_IN; g++) begin : g_in
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[g] <= in_data[g*h3inv_pkg::FIELD_W +: W];
                end
            end
        end

        for (g = 0; g < NP; g++) begin : g_prod
            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[g] <= x_reg[h3inv_pkg::PROD_A[g]] * x_reg[h3inv_pkg::PROD_B[g]];
                end
            end
        end

        for (g = 0; g < NC; g++) begin : g_cof
            assign cof_c[g] = h3inv_pkg::COF_ADD[g]
                ? CW'(p_reg[3*g]) + CW'(p_reg[3*g+1]) - CW'(p_reg[3*g+2])
                : CW'(p_reg[3*g]) - CW'(p_reg[3*g+1]) - CW'(p_reg[3*g+2]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    cof2_reg[g] <= cof_c[g];
                    cof3_reg[g] <= cof2_reg[g];
                    cof4_reg[g] <= cof3_reg[g];
                    cof5_reg[g] <= cof4_reg[g];
                end
            end
        end

        // Determinant terms: split the cofactor so each multiply stays near 32x32.
        for (g = 0; g < ND; g++) begin : g_det
            always_ff @(posedge aclk) begin
                if (en) begin
                    xs1_reg[g] <= x_reg[h3inv_pkg::DET_IN[g]];
                    xs2_reg[g] <= xs1_reg[g];
                    plo_reg[g] <= xs2_reg[g]
                        * $signed({1'b0, cof2_reg[h3inv_pkg::DET_COF[g]][LOW-1:0]});
                    phi_reg[g] <= xs2_reg[g]
                        * $signed(cof2_reg[h3inv_pkg::DET_COF[g]][CW-1:LOW]);
                    dp_reg[g]  <= (DTW'(phi_reg[g]) <<< LOW) + DTW'(plo_reg[g]);
                end
            end
        end

        for (g = 0; g < NC; g++) begin : g_pack
            assign push_data[g*CW +: CW] = cof5_reg[g];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= dp_reg[0] + dp_reg[1] + dp_reg[2] + dp_reg[3] + dp_reg[4];
        end
    end

    assign push_data[NC*CW +: DTW] = det_reg;

endmodule
`default_nettype wire

>>> hw/rtl/h3inv_queue.sv
// Small register FIFO between the front and back parts.
`default_nettype none
module h3inv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = h3inv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic      [WIDTH-1:0]   pop_data,
    output h3inv_pkg::q_status_t    stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    assign wr_next  = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_next  = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign cnt_next = cnt_reg + CNTW'(push) - CNTW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_next;
            end
            if (pop) begin
                rd_reg <= rd_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_reg];
    assign stat.full  = (cnt_reg == CNTW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule
`default_nettype wire

>>> hw/rtl/h3inv_back.sv
// Back part: rounding, pipelined restoring division and output register.
`default_nettype none
module h3inv_back #(
    parameter int DATA_WIDTH    = h3inv_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = h3inv_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              pop_valid,
    input  wire logic [h3inv_pkg::NUM_COF*(2*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)+2)
                       + 3*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)+5-1:0] pop_data,
    output logic                                   pop,
    input  wire logic                              det_only,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [h3inv_pkg::M_TDATA_W-1:0]        out_data,
    output logic [h3inv_pkg::M_TUSER_W-1:0]        out_user
);
    localparam int W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int F   = FRACTION_BITS;
    localparam int CW  = 2*W + 2;
    localparam int DTW = 3*W + 5;
    localparam int NC  = h3inv_pkg::NUM_COF;
    localparam int NW  = ((2*W + 2*F + 3 > 3*W + 5) ? 2*W + 2*F + 3 : 3*W + 5) + 1;
    localparam int RW  = (NW > 4*W + 6) ? NW : 4*W + 6;
    localparam int XW  = (DTW + 2 > 66) ? DTW + 2 : 66;
    localparam int FW  = h3inv_pkg::FIELD_W;

    logic en;
    assign en  = !out_valid || out_ready;
    assign pop = en && pop_valid;

    // Unpack and condition the queue head.
    logic signed [CW-1:0]  cof_in [NC];
    logic signed [DTW-1:0] det_in;
    logic [CW-1:0]         acof   [NC];
    logic [DTW-1:0]        adet;
    logic [RW-1:0]         n_c    [NC];
    logic signed [XW-1:0]  dr_c;
    logic                  fits_c;
    logic [h3inv_pkg::DET_W-1:0] detq_c;

    assign det_in = pop_data[NC*CW +: DTW];
    assign adet   = det_in[DTW-1] ? DTW'(~det_in + 1'b1) : det_in;

    genvar g, s;
    generate
        for (g = 0; g < NC; g++) begin : g_cond
            assign cof_in[g] = pop_data[g*CW +: CW];
            assign acof[g]   = cof_in[g][CW-1] ? CW'(~cof_in[g] + 1'b1) : cof_in[g];
            // 2|n|*2^(2F) + |d|, later divided by 2|d|: rounds half away from zero.
            assign n_c[g]    = (RW'(acof[g]) << (2*F + 1)) + RW'(adet);
        end
        if (F > 0) begin : g_rnd
            assign dr_c = (XW'(det_in) + (XW'(1) <<< (2*F - 1))) >>> (2*F);
        end else begin : g_nornd
            assign dr_c = XW'(det_in);
        end
    endgenerate

    assign fits_c = (dr_c[XW-1:h3inv_pkg::DET_W-1] == '0)
                 || (dr_c[XW-1:h3inv_pkg::DET_W-1] == '1);
    assign detq_c = fits_c ? dr_c[h3inv_pkg::DET_W-1:0]
                  : (dr_c[XW-1] ? {1'b1, {(h3inv_pkg::DET_W-1){1'b0}}}
                                : {1'b0, {(h3inv_pkg::DET_W-1){1'b1}}});

    // Stage B0 registers.
    logic                         vb0_reg;
    logic [RW-1:0]                n0_reg   [NC];
    logic                         neg0_reg [NC];
    logic [RW-1:0]                dd0_reg;
    logic [h3inv_pkg::DET_W-1:0]  detq0_reg;
    logic                         dsat0_reg, sing0_reg, donly0_reg;

    // Division stages: index 0 is the range check, 1..W one quotient bit each.
    logic                         v_reg     [W+1];
    logic [RW-1:0]                rem_reg   [W+1][NC];
    logic [W-1:0]                 q_reg     [W+1][NC];
    logic                         ovf_reg   [W+1][NC];
    logic                         neg_reg   [W+1][NC];
    logic [RW-1:0]                dd_reg    [W+1];
    logic [h3inv_pkg::DET_W-1:0]  detq_reg  [W+1];
    logic                         dsat_reg  [W+1];
    logic                         sing_reg  [W+1];
    logic                         donly_reg [W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb0_reg <= 1'b0;
        end else if (en) begin
            vb0_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NC; k++) begin
                n0_reg[k]   <= n_c[k];
                neg0_reg[k] <= cof_in[k][CW-1] ^ det_in[DTW-1];
            end
            dd0_reg    <= RW'(adet) << 1;
            detq0_reg  <= detq_c;
            dsat0_reg  <= !fits_c;
            sing0_reg  <= (det_in == '0);
            donly0_reg <= det_only;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= vb0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NC; k++) begin
                rem_reg[0][k] <= n0_reg[k];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= (n0_reg[k] >= (dd0_reg << W));
                neg_reg[0][k] <= neg0_reg[k];
            end
            dd_reg[0]    <= dd0_reg;
            detq_reg[0]  <= detq0_reg;
            dsat_reg[0]  <= dsat0_reg;
            sing_reg[0]  <= sing0_reg;
            donly_reg[0] <= donly0_reg;
        end
    end

    generate
        for (s = 1; s <= W; s++) begin : g_div
            localparam int BIT = W - s;
            logic [RW-1:0] dsh;
            assign dsh = dd_reg[s-1] << BIT;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[s] <= 1'b0;
                end else if (en) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int k = 0; k < NC; k++) begin
                        if (rem_reg[s-1][k] >= dsh) begin
                            rem_reg[s][k] <= rem_reg[s-1][k] - dsh;
                            q_reg[s][k]   <= q_reg[s-1][k] | (W'(1) << BIT);
                        end else begin
                            rem_reg[s][k] <= rem_reg[s-1][k];
                            q_reg[s][k]   <= q_reg[s-1][k];
                        end
                        ovf_reg[s][k] <= ovf_reg[s-1][k];
                        neg_reg[s][k] <= neg_reg[s-1][k];
                    end
                    dd_reg[s]    <= dd_reg[s-1];
                    detq_reg[s]  <= detq_reg[s-1];
                    dsat_reg[s]  <= dsat_reg[s-1];
                    sing_reg[s]  <= sing_reg[s-1];
                    donly_reg[s] <= donly_reg[s-1];
                end
            end
        end
    endgenerate

    // Sign, saturation and zeroing of the quotients.
    logic [FW-1:0] inv_c [NC];
    logic [NC-1:0] sat_c;
    logic          use_inv;

    assign use_inv = !sing_reg[W] && !donly_reg[W];

    generate
        for (g = 0; g < NC; g++) begin : g_fin
            logic [W-1:0] q;
            logic         neg, qsat;
            logic [W-1:0] val;
            assign q    = q_reg[W][g];
            assign neg  = neg_reg[W][g];
            assign qsat = ovf_reg[W][g] || (q[W-1] && (!neg || (q[W-2:0] != '0)));
            assign val  = qsat ? (neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                               : (neg ? W'(~q + 1'b1) : q);
            assign inv_c[g] = use_inv ? FW'($signed(val)) : '0;
            assign sat_c[g] = use_inv && qsat;
        end
    endgenerate

    logic                              out_valid_reg;
    logic [h3inv_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic [h3inv_pkg::M_TUSER_W-1:0]   out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NC; k++) begin
                out_data_reg[k*FW +: FW] <= inv_c[k];
            end
            out_data_reg[h3inv_pkg::INV_BITS +: h3inv_pkg::DET_W] <= detq_reg[W];
            out_user_reg[h3inv_pkg::TUSER_SINGULAR]  <= sing_reg[W];
            out_user_reg[h3inv_pkg::TUSER_SATURATED] <= dsat_reg[W] || (sat_c != '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule
`default_nettype wire

>>> hw/rtl/h3inv_checker.sv
// Port-level checks of the Hermitian 3x3 inverse core, bound to the top level.
`default_nettype none
`include "hermitian3x3_inverse_adjugate_core_assert.svh"
module h3inv_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [h3inv_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [h3inv_pkg::M_TUSER_W-1:0]   m_tuser
);
    `H3INV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `H3INV_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid,
        "result valid right after reset")

    `H3INV_ASSERT_NOW(a_sing_inv, aclk, aresetn,
        m_tvalid && m_tuser[h3inv_pkg::TUSER_SINGULAR],
        m_tdata[h3inv_pkg::INV_BITS-1:0] == '0, "singular item with nonzero inverse")

    `H3INV_ASSERT_NOW(a_sing_det, aclk, aresetn,
        m_tvalid && m_tuser[h3inv_pkg::TUSER_SINGULAR],
        (m_tdata[h3inv_pkg::INV_BITS +: h3inv_pkg::DET_W] == '0)
            && !m_tuser[h3inv_pkg::TUSER_SATURATED],
        "singular item with nonzero determinant or saturation")

endmodule

bind hermitian3x3_inverse_adjugate_core h3inv_checker u_checker (.*);
`default_nettype wire

>>> tb/hermitian3x3_inverse_adjugate_core_tb.sv
// Self-checking testbench for the streaming Hermitian 3x3 adjugate inverse core.
`default_nettype none
module hermitian3x3_inverse_adjugate_core_tb;

    localparam int FB = 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef logic signed [31:0] fld_t;
    typedef logic signed [255:0] big_t;

    typedef struct packed {
        logic [h3inv_pkg::M_TUSER_W-1:0] user;
        logic [h3inv_pkg::M_TDATA_W-1:0] data;
    } inv_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [h3inv_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [h3inv_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [h3inv_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // diag_00, diag_11, diag_22, off_01 re/im, off_02 re/im, off_12 re/im; lowest first
    logic [h3inv_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // nine inverse entries (32 each), det_value (64); lowest first
    logic [h3inv_pkg::M_TDATA_W-1:0] m_tdata;
    // singular (bit 0), saturated (bit 1)
    logic [h3inv_pkg::M_TUSER_W-1:0] m_tuser;

    hermitian3x3_inverse_adjugate_core dut (.*);

    // Model copy of the mode register and the queue of predicted results.
    logic det_only_mode = 1'b0;
    inv_result_t inverse_expected[$];
    int mismatches = 0;
    int results_seen = 0;
    int matrices_sent = 0;
    int singular_seen = 0;
    int saturated_seen = 0;
    longint cycle_count = 0;
    bit rx_stall_on = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("hermitian3x3_inverse_adjugate_core regression: fail");
            $finish;
        end
    end

    // Clip a wide signed value to w bits; flags clipping.
    function automatic logic [63:0] clip_to(input big_t v, input int w, inout logic clipped);
        big_t hi, lo;
        hi = (big_t'(1) <<< (w - 1)) - 1;
        lo = -(big_t'(1) <<< (w - 1));
        if (v > hi) begin
            clipped = 1'b1;
            return 64'(hi);
        end
        if (v < lo) begin
            clipped = 1'b1;
            return 64'(lo);
        end
        return 64'(v);
    endfunction

    // Exact adjugate inverse of one matrix, rounded and saturated like the core.
    function automatic inv_result_t predict_inverse(
            input logic [h3inv_pkg::S_TDATA_W-1:0] m);
        big_t e[9];
        big_t cof[9];
        big_t det, dr, num, an, ad, q;
        logic [63:0] qc;
        inv_result_t r;
        logic clipped;
        logic sing;
        for (int i = 0; i < 9; i++) e[i] = big_t'(fld_t'(m[32*i +: 32]));
        // e: d0 d1 d2 ar ai br bi cr ci
        cof[0] = e[1]*e[2] - (e[7]*e[7] + e[8]*e[8]);
        cof[1] = e[0]*e[2] - (e[5]*e[5] + e[6]*e[6]);
        cof[2] = e[0]*e[1] - (e[3]*e[3] + e[4]*e[4]);
        cof[3] = e[5]*e[7] + e[6]*e[8] - e[3]*e[2];
        cof[4] = e[6]*e[7] - e[5]*e[8] - e[4]*e[2];
        cof[5] = e[3]*e[7] - e[4]*e[8] - e[5]*e[1];
        cof[6] = e[3]*e[8] + e[4]*e[7] - e[6]*e[1];
        cof[7] = e[5]*e[3] + e[6]*e[4] - e[0]*e[7];
        cof[8] = e[6]*e[3] - e[5]*e[4] - e[0]*e[8];
        det = e[0]*cof[0] + e[3]*cof[3] + e[4]*cof[4] + e[5]*cof[5] + e[6]*cof[6];
        sing = (det == 0);
        clipped = 1'b0;
        // round half up (floor shift after adding half)
        dr = (det + (big_t'(1) <<< (2*FB - 1))) >>> (2*FB);
        r.data = '0;
        r.data[h3inv_pkg::INV_BITS +: 64] = clip_to(dr, 64, clipped);
        for (int k = 0; k < 9; k++) begin
            if (!sing && !det_only_mode) begin
                num = cof[k] <<< (2*FB);
                an = (num < 0) ? -num : num;
                ad = (det < 0) ? -det : det;
                // half away from zero on magnitudes
                q = (2*an + ad) / (2*ad);
                if ((num < 0) != (det < 0)) q = -q;
                qc = clip_to(q, 32, clipped);
                r.data[32*k +: 32] = qc[31:0];
            end
        end
        r.user[h3inv_pkg::TUSER_SINGULAR] = sing;
        r.user[h3inv_pkg::TUSER_SATURATED] = clipped;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    // Result side: random stall, then compare each accepted item with the oldest prediction.
    initial begin
        inv_result_t want;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= rx_stall_on ? (pick_gap() == 0) : 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (inverse_expected.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[63:0], 64'd0);
                end else begin
                    want = inverse_expected.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[32*k +: 32] !== want.data[32*k +: 32])
                            report_mismatch($sformatf("inv field %0d", k),
                                            64'(m_tdata[32*k +: 32]),
                                            64'(want.data[32*k +: 32]));
                    if (m_tdata[h3inv_pkg::INV_BITS +: 64]
                            !== want.data[h3inv_pkg::INV_BITS +: 64])
                        report_mismatch("det_value", m_tdata[h3inv_pkg::INV_BITS +: 64],
                                        want.data[h3inv_pkg::INV_BITS +: 64]);
                    if (m_tuser[h3inv_pkg::TUSER_SINGULAR]
                            !== want.user[h3inv_pkg::TUSER_SINGULAR])
                        report_mismatch("singular", 64'(m_tuser[h3inv_pkg::TUSER_SINGULAR]),
                                        64'(want.user[h3inv_pkg::TUSER_SINGULAR]));
                    if (m_tuser[h3inv_pkg::TUSER_SATURATED]
                            !== want.user[h3inv_pkg::TUSER_SATURATED])
                        report_mismatch("saturated",
                                        64'(m_tuser[h3inv_pkg::TUSER_SATURATED]),
                                        64'(want.user[h3inv_pkg::TUSER_SATURATED]));
                    if (want.user[h3inv_pkg::TUSER_SINGULAR]) singular_seen++;
                    if (want.user[h3inv_pkg::TUSER_SATURATED]) saturated_seen++;
                end
                results_seen++;
            end
        end
    end

    // Send one matrix; prediction is queued at the accepting edge.
    task automatic send_matrix(input logic [h3inv_pkg::S_TDATA_W-1:0] m, input bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= m;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        inverse_expected.push_back(predict_inverse(m));
        matrices_sent++;
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Wait for all predictions to drain plus pipeline settle time.
    task automatic drain_results();
        stop_sending();
        while (inverse_expected.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_mode(input logic [h3inv_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= h3inv_pkg::CFG_ADDR_W'({h3inv_pkg::REG_DET_ONLY, 2'b00}); pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        det_only_mode = value[0];
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [h3inv_pkg::S_TDATA_W-1:0] pack_matrix(input fld_t v[9]);
        logic [h3inv_pkg::S_TDATA_W-1:0] m;
        for (int i = 0; i < 9; i++) m[32*i +: 32] = v[i];
        return m;
    endfunction

    function automatic fld_t rand_fixed(input int mag_bits);
        fld_t x;
        x = fld_t'($urandom);
        if (mag_bits < 32) x = x >>> (32 - mag_bits);
        return x;
    endfunction

    // Random Hermitian: mostly diagonal dominant with moderate magnitudes, sometimes full range.
    function automatic logic [h3inv_pkg::S_TDATA_W-1:0] rand_matrix();
        fld_t v[9];
        int p, mb;
        p = $urandom_range(0, 99);
        mb = (p < 60) ? $urandom_range(17, 22) : (p < 85 ? $urandom_range(4, 16) : 32);
        for (int i = 0; i < 9; i++) v[i] = rand_fixed(mb);
        if (p < 60)
            for (int i = 0; i < 3; i++)
                v[i] = v[i] + (v[i] < 0 ? -fld_t'(1 << 21) : fld_t'(1 << 21));
        // occasionally a rank-deficient matrix
        if ($urandom_range(0, 19) == 0) begin
            v[3] = 0; v[4] = 0; v[5] = 0; v[6] = 0; v[0] = 0;
        end
        return pack_matrix(v);
    endfunction

    task automatic test_directed();
        fld_t v[9];
        fld_t one;
        one = fld_t'(1 << FB);
        // identity
        v = '{one, one, one, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v), 0);
        // all zero: singular
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v), 0);
        // extremes of every field
        for (int i = 0; i < 9; i++) v[i] = 32'sh7fffffff;
        send_matrix(pack_matrix(v), 0);
        for (int i = 0; i < 9; i++) v[i] = 32'sh80000000;
        send_matrix(pack_matrix(v), 0);
        v = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        send_matrix(pack_matrix(v), 0);
        // tiny diagonal: inverse saturates
        v = '{1, 1, 1, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v), 0);
        v = '{-1, 1, -1, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v), 0);
        // rounding: diag 2, 2 and 3
        v = '{2*one, 2*one, 3*one, 0, 0, 0, 0, 0, 0};
        send_matrix(pack_matrix(v), 0);
        v = '{-3*one, 7*one, one, one, -one, one/2, one/4, -one, one/8};
        send_matrix(pack_matrix(v), 0);
        // rank one: singular with nonzero entries
        v = '{one, one, one, one, 0, one, 0, one, 0};
        send_matrix(pack_matrix(v), 0);
        // alternating bit patterns
        v = '{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
              32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555};
        send_matrix(pack_matrix(v), 0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_matrix(rand_matrix(), 1);
            // run a stretch of items with no receiver stall
            if (n == count / 3) rx_stall_on = 1'b0;
            if (n == count / 3 + 40) rx_stall_on = 1'b1;
            // hold off until the pipe is empty once mid-stream
            if (n == count / 2) begin
                stop_sending();
                while (inverse_expected.size() != 0) @(negedge aclk);
            end
        end
        drain_results();
    endtask

    task automatic test_det_only();
        write_mode(32'hffff_fffe); // upper bits ignored; mode stays 0
        test_random(40);
        write_mode(32'h0000_0001);
        test_directed();
        test_random(80);
        write_mode(32'h0000_0000);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_mode(32'h0);
        test_directed();
        test_random(200);
        test_det_only();
        test_random(100);
        $display("Sent %0d matrices, checked %0d results (%0d singular, %0d saturated).",
                 matrices_sent, results_seen, singular_seen, saturated_seen);
        $display("Covered both mode settings, field extremes, stalls and gaps.");
        if (mismatches == 0) begin
            $display("hermitian3x3_inverse_adjugate_core regression: pass");
        end else begin
            $display("hermitian3x3_inverse_adjugate_core regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
